[rtl/tile_mipmap_box_downsampler_defines.svh]
// ----------------------------------------------------------------------------
// Tile mipmap box downsampler - assertion macros
// Shared property macros, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TILE_MIPMAP_BOX_DOWNSAMPLER_DEFINES_SVH
`define TILE_MIPMAP_BOX_DOWNSAMPLER_DEFINES_SVH

// cond implies prop in the same cycle
`define TMBD_ASSERT_SAME(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// cond implies prop in the next cycle
`define TMBD_ASSERT_NEXT(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[rtl/tmbd_pkg.sv]
// ----------------------------------------------------------------------------
// Tile mipmap box downsampler - package
// Word types, defaults and the two-pixel blend shared by the block.
// ----------------------------------------------------------------------------
package tmbd_pkg;

    localparam int TILE_SIZE_DEF   = 16;
    localparam int LEVEL_COUNT_DEF = 4;

    localparam logic [23:0] BLEND_MASK = 24'hFEFEFE;
    localparam logic [7:0]  BYTE_MASK  = 8'hFF;

    typedef struct packed {
        logic [31:0] pixel;
        logic [7:0]  sprite_index;
        logic        tile_start;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  level;
        logic [6:0]  atlas_x;
        logic [6:0]  atlas_y;
        logic [31:0] color;
        logic        last_of_run;
    } out_word_t;

    // pixel handed from the input buffer to the reduction engine
    typedef struct packed {
        logic [31:0] color;
        logic [7:0]  sprite;
    } job_t;

    // alpha: plain mean; colour bytes: mean with the low bit of each byte dropped
    function automatic logic [31:0] mix2(input logic [31:0] a, input logic [31:0] b);
        logic [8:0]  alpha_sum;
        logic [24:0] low_sum;
        begin
            alpha_sum = {1'b0, a[31:24] & BYTE_MASK} + {1'b0, b[31:24] & BYTE_MASK};
            low_sum   = {1'b0, a[23:0] & BLEND_MASK} + {1'b0, b[23:0] & BLEND_MASK};
            mix2      = {alpha_sum[8:1], low_sum[24:1]};
        end
    endfunction

endpackage

[rtl/tmbd_feed.sv]
// ----------------------------------------------------------------------------
// Tile mipmap box downsampler - input buffer
// Holds one accepted word, tracks the raster position and the tile sprite.
// ----------------------------------------------------------------------------
module tmbd_feed #(
    parameter int TILE_SIZE = tmbd_pkg::TILE_SIZE_DEF,
    localparam int CW = $clog2(TILE_SIZE)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tmbd_pkg::in_word_t in_word,
    output logic               job_valid,
    output tmbd_pkg::job_t     job,
    output logic [CW-1:0]      job_x,
    output logic [CW-1:0]      job_y,
    input  logic               job_take
);

    logic               buf_valid_reg;
    logic               buf_valid_next;
    tmbd_pkg::job_t     buf_job_reg;
    logic [CW-1:0]      buf_x_reg;
    logic [CW-1:0]      buf_y_reg;
    logic [CW-1:0]      pos_x_reg;
    logic [CW-1:0]      pos_x_next;
    logic [CW-1:0]      pos_y_reg;
    logic [CW-1:0]      pos_y_next;
    logic [7:0]         sprite_reg;
    logic [7:0]         sprite_next;
    logic [CW-1:0]      cur_x;
    logic [CW-1:0]      cur_y;
    logic               accept;

    assign in_ready = !buf_valid_reg || job_take;
    assign accept   = in_valid && in_ready;

    assign cur_x = in_word.tile_start ? '0 : pos_x_reg;
    assign cur_y = in_word.tile_start ? '0 : pos_y_reg;

    always_comb
    begin
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        sprite_next    = sprite_reg;
        buf_valid_next = buf_valid_reg;
        if (job_take)
        begin
            buf_valid_next = 1'b0;
        end
        if (accept)
        begin
            buf_valid_next = 1'b1;
            // wrap at the end of the row and at the end of the tile
            if (cur_x == CW'(TILE_SIZE - 1))
            begin
                pos_x_next = '0;
                pos_y_next = (cur_y == CW'(TILE_SIZE - 1)) ? '0 : cur_y + 1'b1;
            end
            else
            begin
                pos_x_next = cur_x + 1'b1;
                pos_y_next = cur_y;
            end
            if (cur_x == '0 && cur_y == '0)
            begin
                sprite_next = in_word.sprite_index;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            sprite_reg    <= '0;
        end
        else
        begin
            buf_valid_reg <= buf_valid_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            sprite_reg    <= sprite_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            buf_job_reg.color  <= in_word.pixel;
            buf_job_reg.sprite <= sprite_next;
            buf_x_reg          <= cur_x;
            buf_y_reg          <= cur_y;
        end
    end

    assign job_valid = buf_valid_reg;
    assign job       = buf_job_reg;
    assign job_x     = buf_x_reg;
    assign job_y     = buf_y_reg;

endmodule

[rtl/tmbd_engine.sv]
// ----------------------------------------------------------------------------
// Tile mipmap box downsampler - reduction engine
// Level store, per-level left-neighbour registers, blend step, result register.
// ----------------------------------------------------------------------------
`include "tile_mipmap_box_downsampler_defines.svh"

module tmbd_engine #(
    parameter int TILE_SIZE   = tmbd_pkg::TILE_SIZE_DEF,
    parameter int LEVEL_COUNT = tmbd_pkg::LEVEL_COUNT_DEF,
    localparam int CW = $clog2(TILE_SIZE)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  tmbd_pkg::job_t      job,
    input  logic [CW-1:0]       job_x,
    input  logic [CW-1:0]       job_y,
    output logic                job_take,
    output logic                out_valid,
    input  logic                out_ready,
    output tmbd_pkg::out_word_t out_word
);

    localparam int DEPTH = 2 * TILE_SIZE * TILE_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(TILE_SIZE + 1);
    localparam int LW    = $clog2(LEVEL_COUNT + 1);
    localparam int BI    = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WRITE = 2'd1;
    localparam logic [1:0] ST_MIX   = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [31:0]         col_reg;
    logic [CW-1:0]       x_reg;
    logic [CW-1:0]       y_reg;
    logic [SW-1:0]       size_reg;
    logic [AW-1:0]       base_reg;
    logic [LW-1:0]       lvl_reg;
    logic [7:0]          sprite_reg;
    logic [31:0]         blq_reg;
    logic [31:0]         bl_reg [LEVEL_COUNT];
    logic [31:0]         mem [DEPTH];
    logic [31:0]         rd_tl_reg;
    logic [31:0]         rd_tr_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    tmbd_pkg::out_word_t out_reg;

    logic [BI-1:0]       bl_idx;
    logic [AW-1:0]       row_cur;
    logic [AW-1:0]       row_prev;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       tl_addr;
    logic [AW-1:0]       tr_addr;
    logic                wr_en;
    logic                quad;
    logic                adv;
    logic                done_after;
    logic                free;
    logic [LW-1:0]       lvl_inc;
    logic [SW-1:0]       half;
    logic [CW-1:0]       xn;
    logic [CW-1:0]       yn;
    logic [31:0]         blend;
    tmbd_pkg::out_word_t res;

    assign bl_idx   = lvl_reg[BI-1:0];
    assign row_cur  = base_reg + AW'(y_reg) * AW'(size_reg);
    assign row_prev = base_reg + AW'(y_reg - 1'b1) * AW'(size_reg);
    assign wr_addr  = row_cur + AW'(x_reg);
    assign tl_addr  = row_prev + AW'(x_reg) - AW'(1);
    assign tr_addr  = row_prev + AW'(x_reg);

    assign wr_en = (state_reg == ST_WRITE);
    assign quad  = wr_en && x_reg[0] && y_reg[0] && (lvl_reg < LW'(LEVEL_COUNT));

    // blend step: hold while the result register is full and out_ready is low
    assign adv        = (state_reg == ST_MIX) && (!out_valid_reg || out_ready);
    assign lvl_inc    = lvl_reg + 1'b1;
    assign done_after = (lvl_inc == LW'(LEVEL_COUNT));
    assign half       = size_reg >> 1;
    assign xn         = x_reg >> 1;
    assign yn         = y_reg >> 1;
    assign blend      = tmbd_pkg::mix2(tmbd_pkg::mix2(rd_tl_reg, rd_tr_reg),
                                       tmbd_pkg::mix2(col_reg, blq_reg));

    assign free = (state_reg == ST_IDLE) || (wr_en && !quad) || (adv && done_after);
    assign job_take = free && job_valid;

    always_comb
    begin
        res.level       = 3'(lvl_inc);
        res.atlas_x     = 7'(7'(sprite_reg[3:0]) * 7'(half) + 7'(xn));
        res.atlas_y     = 7'(7'(sprite_reg[7:4]) * 7'(half) + 7'(yn));
        res.color       = blend;
        res.last_of_run = !((lvl_inc < LW'(LEVEL_COUNT)) && xn[0] && yn[0]);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (quad)
                begin
                    state_next = ST_MIX;
                end
                else if (!job_valid)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MIX:
            begin
                if (adv)
                begin
                    if (!done_after || job_valid)
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (adv)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working pixel: load a fresh word, or step up one level after a blend
    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            col_reg    <= job.color;
            x_reg      <= job_x;
            y_reg      <= job_y;
            size_reg   <= SW'(TILE_SIZE);
            base_reg   <= '0;
            lvl_reg    <= '0;
            sprite_reg <= job.sprite;
        end
        else if (adv)
        begin
            col_reg  <= blend;
            x_reg    <= xn;
            y_reg    <= yn;
            size_reg <= half;
            base_reg <= base_reg + AW'(size_reg) * AW'(size_reg);
            lvl_reg  <= lvl_inc;
        end
        if (adv)
        begin
            out_reg <= res;
        end
    end

    // left neighbour of an odd column is the previous word written at that level
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            blq_reg        <= bl_reg[bl_idx];
            bl_reg[bl_idx] <= col_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= col_reg;
        end
        if (quad)
        begin
            rd_tl_reg <= mem[tl_addr];
            rd_tr_reg <= mem[tr_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    `TMBD_ASSERT_SAME(a_no_rw_clash, quad, (tl_addr != wr_addr) && (tr_addr != wr_addr), "store read hits the entry written in the same cycle")
    `TMBD_ASSERT_NEXT(a_quad_to_mix, quad, state_reg == ST_MIX, "completed quad did not enter the blend step")
    `TMBD_ASSERT_SAME(a_mix_odd, state_reg == ST_MIX, x_reg[0] && y_reg[0], "blend step on an even coordinate")
    `TMBD_ASSERT_SAME(a_write_level, state_reg == ST_WRITE, lvl_reg < LW'(LEVEL_COUNT), "store write beyond the last kept level")

endmodule

[rtl/tile_mipmap_box_downsampler.sv]
// ----------------------------------------------------------------------------
// Tile mipmap box downsampler - top level
// 2x2 box reduction of a raster-order tile into mipmap levels 1..LEVEL_COUNT.
// ----------------------------------------------------------------------------
//  channel  handshake             word                   carries
//  -------  --------------------  ---------------------  ------------------------
//  in       in_valid / in_ready   in_word  (in_word_t)   one tile pixel
//  out      out_valid / out_ready out_word (out_word_t)  one reduced pixel
//
//  A word that closes no quad needs only the store write in the engine.
//  Each closed quad adds a blend step and the write one level up; the upper
//  pair is read during the write, and the top level is never written back.
//  Reset clears control only; store entries are undefined until written.
//  A full result register holds the blend step unless out_ready is high; one input word waits in a buffer.
// ----------------------------------------------------------------------------
module tile_mipmap_box_downsampler #(
    parameter int TILE_SIZE   = tmbd_pkg::TILE_SIZE_DEF,
    parameter int LEVEL_COUNT = tmbd_pkg::LEVEL_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tmbd_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output tmbd_pkg::out_word_t out_word
);

    localparam int CW = $clog2(TILE_SIZE);

    logic           job_valid;
    logic           job_take;
    tmbd_pkg::job_t job;
    logic [CW-1:0]  job_x;
    logic [CW-1:0]  job_y;

    tmbd_feed #(
        .TILE_SIZE (TILE_SIZE)
    ) u_feed (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .job_valid (job_valid),
        .job       (job),
        .job_x     (job_x),
        .job_y     (job_y),
        .job_take  (job_take)
    );

    tmbd_engine #(
        .TILE_SIZE   (TILE_SIZE),
        .LEVEL_COUNT (LEVEL_COUNT)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_x     (job_x),
        .job_y     (job_y),
        .job_take  (job_take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule

[tb/tile_mipmap_box_downsampler_tb.sv]
// ----------------------------------------------------------------------------
// Tile mipmap box downsampler - testbench
// Streams tile pixels through the block and predicts every 2x2 reduced word
// from a local copy of the level store. Checks each output word, field by
// field and in order. The input side sends in random bursts and the output
// side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tile_mipmap_box_downsampler_tb;

    localparam int TILE_DIM     = 16;
    localparam int LEVELS       = 4;
    localparam int TILE_AREA    = TILE_DIM * TILE_DIM;
    localparam int ATLAS_COLS   = 16;
    localparam int STORE_DEPTH  = 2 * TILE_AREA;
    localparam int DIRECTED_CNT = 25;
    localparam int RANDOM_ITEMS = 145;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 200000;

    // ------------------------------------------------------------------------
    // reduction predictor and expected-word store
    // ------------------------------------------------------------------------
    class mip_scoreboard;
        int                  raster_pos;
        int                  tile_sprite;
        logic [31:0]         level_store [STORE_DEPTH];
        tmbd_pkg::out_word_t expected_q [$];
        int                  errors;
        int                  pixels_in;
        int                  words_out;
        int                  level_hits [LEVELS + 1];

        function new();
            raster_pos  = 0;
            tile_sprite = 0;
            errors      = 0;
            pixels_in   = 0;
            words_out   = 0;
            foreach (level_store[i])
                level_store[i] = '0;
            foreach (level_hits[i])
                level_hits[i] = 0;
        endfunction

        // alpha is a plain mean; each colour byte is the sum of the two halves
        function logic [31:0] average_pair(logic [31:0] a, logic [31:0] b);
            logic [8:0]  alpha_sum;
            logic [31:0] blended;
            alpha_sum = {1'b0, a[31:24]} + {1'b0, b[31:24]};
            blended[31:24] = alpha_sum[8:1];
            for (int k = 0; k < 3; k++)
                blended[8*k +: 8] = {1'b0, a[8*k+1 +: 7]} + {1'b0, b[8*k+1 +: 7]};
            return blended;
        endfunction

        function void note_pixel(tmbd_pkg::in_word_t w);
            int                  pos;
            int                  x;
            int                  y;
            int                  size;
            int                  half;
            int                  base;
            logic [31:0]         c;
            logic [31:0]         tl;
            logic [31:0]         tr;
            logic [31:0]         bl;
            tmbd_pkg::out_word_t r;
            tmbd_pkg::out_word_t held;
            bit                  have_held;
            pos = w.tile_start ? 0 : raster_pos;
            if (pos == 0)
                tile_sprite = w.sprite_index;
            x         = pos % TILE_DIM;
            y         = pos / TILE_DIM;
            size      = TILE_DIM;
            base      = 0;
            c         = w.pixel;
            have_held = 1'b0;
            pixels_in++;
            for (int lvl = 1; lvl <= LEVELS; lvl++)
            begin
                level_store[base + x + y * size] = c;
                if (size < 2 || (x % 2) == 0 || (y % 2) == 0)
                    break;
                tl   = level_store[base + (x - 1) + (y - 1) * size];
                tr   = level_store[base + x + (y - 1) * size];
                bl   = level_store[base + (x - 1) + y * size];
                c    = average_pair(average_pair(tl, tr), average_pair(c, bl));
                base = base + size * size;
                half = size / 2;
                x    = x / 2;
                y    = y / 2;
                size = half;
                r.level       = 3'(lvl);
                r.atlas_x     = 7'((tile_sprite % ATLAS_COLS) * half + x);
                r.atlas_y     = 7'((tile_sprite / ATLAS_COLS) * half + y);
                r.color       = c;
                r.last_of_run = 1'b0;
                // hold each word back until we know whether it closes the run
                if (have_held)
                    expected_q.insert(expected_q.size(), held);
                held      = r;
                have_held = 1'b1;
            end
            if (have_held)
            begin
                held.last_of_run = 1'b1;
                expected_q.insert(expected_q.size(), held);
            end
            raster_pos = (pos + 1) % TILE_AREA;
        endfunction

        function void check_word(tmbd_pkg::out_word_t got);
            tmbd_pkg::out_word_t exp_w;
            words_out++;
            if (expected_q.size() == 0)
            begin
                $error("output word with nothing expected: %h", got);
                errors++;
                return;
            end
            exp_w = expected_q.pop_front();
            if (exp_w.level >= 1 && exp_w.level <= LEVELS)
                level_hits[exp_w.level]++;
            if (got.level !== exp_w.level)
            begin
                $error("level: expected %0d, got %0d", exp_w.level, got.level);
                errors++;
            end
            if (got.atlas_x !== exp_w.atlas_x)
            begin
                $error("atlas_x: expected %0d, got %0d", exp_w.atlas_x, got.atlas_x);
                errors++;
            end
            if (got.atlas_y !== exp_w.atlas_y)
            begin
                $error("atlas_y: expected %0d, got %0d", exp_w.atlas_y, got.atlas_y);
                errors++;
            end
            if (got.color !== exp_w.color)
            begin
                $error("color: expected %h, got %h", exp_w.color, got.color);
                errors++;
            end
            if (got.last_of_run !== exp_w.last_of_run)
            begin
                $error("last_of_run: expected %0b, got %0b",
                       exp_w.last_of_run, got.last_of_run);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    tmbd_pkg::in_word_t  in_word   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    tmbd_pkg::out_word_t out_word;

    mip_scoreboard sb = new();

    int  burst_left  = 0;
    int  sent_count  = 0;
    int  cycle_count = 0;

    tile_mipmap_box_downsampler i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sample both handshakes at the edge, input first
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_pixel(in_word);
            if (out_valid && out_ready)
                sb.check_word(out_word);
        end
    end

    // output side: runs of always-ready, coin flips, long stalls and toggling
    initial
    begin
        int mode;
        int span;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 40);
            for (int k = 0; k < span; k++)
            begin
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= (k >= span - 1) || (k > 12);
                    default: out_ready <= k[0];
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tile_mipmap_box_downsampler_tb: done, errors");
        $finish;
    end

    // send one word; when the current burst is used up, start a new one, mostly after an idle gap
    task automatic send_pixel(input logic [31:0] pix, input logic [7:0] spr,
                              input logic start);
        tmbd_pkg::in_word_t w;
        int                 gap;
        w.pixel        = pix;
        w.sprite_index = spr;
        w.tile_start   = start;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 5) == 0) ? 48 : $urandom_range(1, 16);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        sent_count++;
    endtask

    task automatic send_tile(input int length, input logic first_start);
        logic [31:0] pix;
        for (int i = 0; i < length; i++)
        begin
            case ($urandom_range(0, 7))
                0:       pix = 32'h0000_0000;
                1:       pix = 32'hFFFF_FFFF;
                default: pix = $urandom;
            endcase
            send_pixel(pix, 8'($urandom_range(0, 255)), (i == 0) ? first_start : 1'b0);
        end
    endtask

    initial
    begin
        logic [31:0] pix;
        int          rand_items;
        int          length;
        bit          first_tile;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner sprite, extreme colours; the last word restarts mid-tile
        for (int i = 0; i < DIRECTED_CNT; i++)
        begin
            case (i % 5)
                0:       pix = 32'hFFFF_FFFF;
                1:       pix = 32'h0000_0000;
                2:       pix = 32'h0101_0101;
                3:       pix = 32'hFF00_0000;
                default: pix = 32'h80FF_7F01;
            endcase
            send_pixel(pix, (i == DIRECTED_CNT - 1) ? 8'h00 : 8'hFF,
                       (i == 0) || (i == DIRECTED_CNT - 1));
        end

        // half a tile first to reach level three, then short broken tiles
        rand_items = 0;
        first_tile = 1'b1;
        while (rand_items < RANDOM_ITEMS)
        begin
            if (first_tile || $urandom_range(0, 7) == 0)
                length = TILE_AREA / 2;
            else
                length = $urandom_range(1, 40);
            if (length > RANDOM_ITEMS - rand_items)
                length = RANDOM_ITEMS - rand_items;
            // a low tile_start carries on from where the last run stopped
            send_tile(length, first_tile || ($urandom_range(0, 3) != 0));
            rand_items = rand_items + length;
            first_tile = 1'b0;
        end
        in_valid <= 1'b0;
        @(posedge clk);

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d pixel words in, %0d reduced words out",
                 sb.pixels_in, sb.words_out);
        $display("reduced words per level 1..4: %0d %0d %0d %0d",
                 sb.level_hits[1], sb.level_hits[2], sb.level_hits[3], sb.level_hits[4]);
        if (sb.errors == 0)
            $display("tile_mipmap_box_downsampler_tb: done, clean");
        else
            $display("tile_mipmap_box_downsampler_tb: done, errors");
        $finish;
    end

endmodule
